@@ hdl/bst_pkg.sv @@
`timescale 1ns / 1ps

package bst_pkg;

	// Default number of entries in the store.
	localparam int CAPACITY_DEF = 16;

	// Width of one stored value and of the result count field.
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// Action codes carried by an input item.
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	// Status codes returned with every result item.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [VALUE_W-1:0] value;
	} bst_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               is_member;
		logic [COUNT_W-1:0] count;
	} bst_out_t;

endpackage

@@ hdl/bst_ram.sv @@
`timescale 1ns / 1ps

module bst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/bst_ctrl.sv @@
`timescale 1ns / 1ps

module bst_ctrl #(
	parameter int CAPACITY = bst_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  bst_pkg::bst_in_t            req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output bst_pkg::bst_out_t           res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [bst_pkg::VALUE_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [bst_pkg::VALUE_W-1:0] mem_rdata
);
	import bst_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_SCAN_RD  = 6'b000010,
		S_SCAN_CMP = 6'b000100,
		S_SHIFT_RD = 6'b001000,
		S_SHIFT_WR = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t             state_q;
	logic [1:0]         act_q;
	logic [VALUE_W-1:0] value_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [1:0]         status_q;
	logic               member_q;

	logic               req_take;
	logic               is_full;
	logic               hit;
	logic [CW-1:0]      idx_inc;
	logic               scan_last;
	logic               shift_more;
	logic [CW+COUNT_W-1:0] count_ext;

	// Compare logic: request take, full check, scan match and the loop bounds.
	assign req_take   = req_valid && (state_q == S_IDLE);
	assign is_full    = (count_q == CW'(CAPACITY));
	assign hit        = (mem_rdata == value_q);
	assign idx_inc    = idx_q + 1'b1;
	assign scan_last  = (idx_inc == count_q);
	assign shift_more = (({1'b0, idx_inc} + 1'b1) < {1'b0, count_q});

	// Entry memory ports: append on add, read during the scan, move down one place on remove.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = req.value;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		if (req_take && (req.action == ACT_ADD) && !is_full) begin
			mem_we = 1'b1;
		end
		if (state_q == S_SHIFT_WR) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q[AW-1:0];
			mem_wdata = mem_rdata;
		end
		if (state_q == S_SCAN_RD) begin
			mem_re = 1'b1;
		end
		if (state_q == S_SHIFT_RD) begin
			mem_re    = 1'b1;
			mem_raddr = idx_inc[AW-1:0];
		end
	end

	// Sequencer: each entry is read in S_SCAN_RD and compared in S_SCAN_CMP.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			act_q    <= ACT_CLEAR;
			value_q  <= '0;
			status_q <= ST_OK;
			member_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q    <= req.action;
						value_q  <= req.value;
						idx_q    <= '0;
						status_q <= ST_OK;
						member_q <= 1'b0;
						unique case (req.action) inside
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							ACT_ADD: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_RESP;
							end
							ACT_REMOVE, ACT_QUERY: begin
								if (count_q == '0) begin
									if (req.action == ACT_REMOVE) begin
										status_q <= ST_NOT_FOUND;
									end
									state_q <= S_RESP;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (hit) begin
						if (act_q == ACT_QUERY) begin
							member_q <= 1'b1;
							state_q  <= S_RESP;
						end else if (scan_last) begin
							count_q <= count_q - 1'b1;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SHIFT_RD;
						end
					end else if (scan_last) begin
						if (act_q == ACT_REMOVE) begin
							status_q <= ST_NOT_FOUND;
						end
						state_q <= S_RESP;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					idx_q <= idx_inc;
					if (shift_more) begin
						state_q <= S_SHIFT_RD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result fields; the count field carries the low bits of the entry count.
	assign count_ext     = {{COUNT_W{1'b0}}, count_q};
	assign res.status    = status_q;
	assign res.is_member = member_q;
	assign res.count     = count_ext[COUNT_W-1:0];
	assign res_valid     = (state_q == S_RESP);
	assign req_stall     = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_WR) |-> ({1'b0, idx_inc} < {1'b0, count_q}))
		else $error("shift moves an entry from beyond the count");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q != S_IDLE))
		else $error("accepted item did not start processing");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("pending result changed before it was taken");
`endif

endmodule

@@ hdl/bounded_set_table.sv @@
`timescale 1ns / 1ps

// Bounded set table: a store of up to CAPACITY signed 32-bit values kept in
// insertion order in a single-port-read entry memory. Each item carries one
// action (clear, add, remove, query) and returns exactly one result item with
// a status, a membership flag and the entry count after the action. Query and
// remove walk the entries with one shared comparator, reading one entry at a
// time through the memory's single registered read port; a remove that finds
// its value then shifts each later entry down one place through the same port.
// An empty store answers query and remove without walking the entries. The
// next item is taken once the result is placed in the output register, so a
// result still waiting on a stalled consumer does not hold up the next item's
// work.
module bounded_set_table #(
	parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  bst_pkg::bst_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output bst_pkg::bst_out_t rsp
);
	import bst_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic               res_valid;
	logic               res_ready;
	bst_out_t           res;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;
	logic               rsp_valid_q;
	bst_out_t           rsp_q;

	bst_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bst_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: free when empty or when its item leaves this cycle.
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
